@@ design/midi_pkt_pkg.sv @@
package midi_pkt_pkg;

  // Status bytes with special handling
  localparam logic [7:0] ST_SYSEX_START = 8'hF0;
  localparam logic [7:0] ST_MTC_QFRAME  = 8'hF1;
  localparam logic [7:0] ST_SONG_POS    = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
  localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;
  localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
  localparam logic [7:0] ST_SYSTEM_MIN  = 8'hF0;
  localparam logic [7:0] ST_REALTIME_MIN = 8'hF8;
  localparam logic [7:0] NO_STATUS      = 8'h00;

  // Channel message kinds (bits 6:4 of the status) with one data byte
  localparam logic [2:0] KIND_PROG_CHANGE = 3'h4;
  localparam logic [2:0] KIND_CHAN_PRESS  = 3'h5;

  // Code index numbers
  localparam logic [3:0] CIN_NONE      = 4'h0;
  localparam logic [3:0] CIN_COMMON2   = 4'h2;
  localparam logic [3:0] CIN_COMMON3   = 4'h3;
  localparam logic [3:0] CIN_SX_DATA   = 4'h4;
  localparam logic [3:0] CIN_COMMON1   = 4'h5;
  localparam logic [3:0] CIN_SINGLE    = 4'hF;

  localparam logic [1:0] SYSEX_PKT_LEN = 2'd3;

  typedef struct packed {
    logic [3:0] cin;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       last;
  } packet_t;

  // Up to two packets per input byte
  typedef struct packed {
    packet_t    pkt_a;
    packet_t    pkt_b;
    logic [1:0] count;
  } dec_out_t;

  function automatic logic [1:0] msg_length(input logic [7:0] s);
    logic [1:0] len;
    if (s[7] && (s < ST_SYSTEM_MIN)) begin
      if ((s[6:4] == KIND_PROG_CHANGE) || (s[6:4] == KIND_CHAN_PRESS)) begin
        len = 2'd2;
      end else begin
        len = 2'd3;
      end
    end else begin
      case (s)
        ST_MTC_QFRAME: len = 2'd2;
        ST_SONG_POS:   len = 2'd3;
        ST_SONG_SEL:   len = 2'd2;
        ST_TUNE_REQ:   len = 2'd1;
        default:       len = 2'd0;
      endcase
    end
    return len;
  endfunction

  function automatic logic [3:0] msg_cin(input logic [7:0] s);
    logic [3:0] cin;
    if (s[7] && (s < ST_SYSTEM_MIN)) begin
      cin = s[7:4];
    end else begin
      case (s)
        ST_MTC_QFRAME: cin = CIN_COMMON2;
        ST_SONG_POS:   cin = CIN_COMMON3;
        ST_SONG_SEL:   cin = CIN_COMMON2;
        ST_TUNE_REQ:   cin = CIN_COMMON1;
        default:       cin = CIN_NONE;
      endcase
    end
    return cin;
  endfunction

endpackage

@@ design/midi_pkt_decode.sv @@
module midi_pkt_decode (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  logic [7:0]                 midi_byte,
  output midi_pkt_pkg::dec_out_t     dec
);

  logic [7:0]       rs_r, rs_nxt;
  logic [2:0][7:0]  pb_r, pb_nxt;
  logic [1:0]       rc_r, rc_nxt;
  logic [1:0]       ec_r, ec_nxt;
  logic             sx_r, sx_nxt;

  logic [2:0][7:0]  pb_t;
  logic [1:0]       rc_t;
  logic [1:0]       ec_t;
  logic [1:0]       cnt;
  logic [1:0]       st_len;
  logic             take;
  logic [1:0]       n;
  midi_pkt_pkg::packet_t pkt_a, pkt_b, pkt_st;

  function automatic midi_pkt_pkg::packet_t make_pkt(input logic [3:0] cin,
                                                     input logic [1:0] len,
                                                     input logic [2:0][7:0] pb);
    midi_pkt_pkg::packet_t p;
    p.cin  = cin;
    p.b0   = (len >= 2'd1) ? pb[0] : 8'h00;
    p.b1   = (len >= 2'd2) ? pb[1] : 8'h00;
    p.b2   = (len == 2'd3) ? pb[2] : 8'h00;
    p.last = 1'b0;
    return p;
  endfunction

  always_comb begin
    rs_nxt = rs_r;
    pb_nxt = pb_r;
    rc_nxt = rc_r;
    ec_nxt = ec_r;
    sx_nxt = sx_r;
    pb_t   = pb_r;
    rc_t   = rc_r;
    ec_t   = ec_r;
    pkt_a  = '0;
    pkt_b  = '0;
    pkt_st = '0;
    n      = 2'd0;
    take   = 1'b0;
    cnt    = rc_r[1] ? 2'd2 : rc_r;
    st_len = midi_pkt_pkg::msg_length(midi_byte);

    if (fire) begin
      if (midi_byte >= midi_pkt_pkg::ST_REALTIME_MIN) begin
        // real-time: pass through, leave message state alone
        pkt_a.cin = midi_pkt_pkg::CIN_SINGLE;
        pkt_a.b0  = midi_byte;
        n = 2'd1;
      end else if (midi_byte[7]) begin
        take = 1'b1;
        if (sx_r) begin
          sx_nxt = 1'b0;
          if (midi_byte == midi_pkt_pkg::ST_SYSEX_END) begin
            take = 1'b0;
            // end byte on an empty packet starts from a clean packet
            if (cnt == 2'd0) begin
              pb_t = '0;
            end
            pb_t[cnt] = midi_pkt_pkg::ST_SYSEX_END;
            pkt_a = make_pkt(midi_pkt_pkg::CIN_SX_DATA + {2'b00, cnt} + 4'd1,
                             cnt + 2'd1, pb_t);
            n = 2'd1;
            pb_nxt = pb_t;
            rc_nxt = 2'd0;
            ec_nxt = 2'd0;
          end else if (cnt != 2'd0) begin
            // close the open run before taking the new status
            pkt_a = make_pkt(midi_pkt_pkg::CIN_SX_DATA + {2'b00, cnt}, cnt, pb_r);
            n = 2'd1;
          end
        end
        if (take) begin
          pb_nxt = {8'h00, 8'h00, midi_byte};
          rc_nxt = 2'd1;
          if (midi_byte == midi_pkt_pkg::ST_SYSEX_START) begin
            ec_nxt = midi_pkt_pkg::SYSEX_PKT_LEN;
            sx_nxt = 1'b1;
            rs_nxt = midi_pkt_pkg::NO_STATUS;
          end else begin
            rs_nxt = (midi_byte < midi_pkt_pkg::ST_SYSTEM_MIN) ?
                     midi_byte : midi_pkt_pkg::NO_STATUS;
            ec_nxt = st_len;
            if (st_len == 2'd1) begin
              pkt_st = make_pkt(midi_pkt_pkg::msg_cin(midi_byte), 2'd1,
                                {8'h00, 8'h00, midi_byte});
              if (n == 2'd0) begin
                pkt_a = pkt_st;
              end else begin
                pkt_b = pkt_st;
              end
              n = n + 2'd1;
              rc_nxt = 2'd0;
              ec_nxt = 2'd0;
            end
          end
        end
      end else if (sx_r) begin
        if (rc_r == 2'd0) begin
          pb_t = {8'h00, 8'h00, midi_byte};
          rc_t = 2'd1;
          ec_nxt = midi_pkt_pkg::SYSEX_PKT_LEN;
        end else if (rc_r < 2'd3) begin
          pb_t[rc_r] = midi_byte;
          rc_t = rc_r + 2'd1;
        end
        pb_nxt = pb_t;
        rc_nxt = rc_t;
        if (rc_t == midi_pkt_pkg::SYSEX_PKT_LEN) begin
          pkt_a = make_pkt(midi_pkt_pkg::CIN_SX_DATA, midi_pkt_pkg::SYSEX_PKT_LEN, pb_t);
          n = 2'd1;
          rc_nxt = 2'd0;
          ec_nxt = 2'd0;
        end
      end else begin
        if (rc_r == 2'd0) begin
          // running status: data byte without a fresh status
          if (rs_r != midi_pkt_pkg::NO_STATUS) begin
            pb_t = {8'h00, midi_byte, rs_r};
            rc_t = 2'd2;
            ec_t = midi_pkt_pkg::msg_length(rs_r);
          end
        end else if ((ec_r != 2'd0) && (rc_r < ec_r) && (rc_r < 2'd3)) begin
          pb_t[rc_r] = midi_byte;
          rc_t = rc_r + 2'd1;
        end
        pb_nxt = pb_t;
        rc_nxt = rc_t;
        ec_nxt = ec_t;
        if ((ec_t != 2'd0) && (rc_t == ec_t)) begin
          pkt_a = make_pkt(midi_pkt_pkg::msg_cin(pb_t[0]), rc_t, pb_t);
          n = 2'd1;
          rc_nxt = 2'd0;
          ec_nxt = 2'd0;
        end
      end
    end

    // flag the final packet of this byte
    pkt_a.last = (n == 2'd1);
    pkt_b.last = (n == 2'd2);
    dec.pkt_a = pkt_a;
    dec.pkt_b = pkt_b;
    dec.count = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r <= midi_pkt_pkg::NO_STATUS;
      pb_r <= '0;
      rc_r <= 2'd0;
      ec_r <= 2'd0;
      sx_r <= 1'b0;
    end else begin
      rs_r <= rs_nxt;
      pb_r <= pb_nxt;
      rc_r <= rc_nxt;
      ec_r <= ec_nxt;
      sx_r <= sx_nxt;
    end
  end

endmodule

@@ design/midi_pkt_fifo.sv @@
module midi_pkt_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  midi_pkt_pkg::dec_out_t push,
  input  logic                   pop,
  output midi_pkt_pkg::packet_t  head,
  output logic                   not_empty,
  output logic                   room
);

  midi_pkt_pkg::packet_t mem_r [4];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] wp_b;

  assign wp_b      = wp_r + 2'd1;
  assign head      = mem_r[rp_r];
  assign not_empty = (cnt_r != 3'd0);
  // space for the worst case of two beats from one byte
  assign room      = (cnt_r <= 3'd2);

  always_comb begin
    wp_nxt  = wp_r + push.count;
    rp_nxt  = pop ? (rp_r + 2'd1) : rp_r;
    cnt_nxt = cnt_r + {1'b0, push.count} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wp_r] <= push.pkt_a;
    end
    if (push.count == 2'd2) begin
      mem_r[wp_b] <= push.pkt_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ design/midi_to_usb_midi_packetizer.sv @@
// Converts a serial MIDI byte stream into USB-MIDI event packets on cable 0.
// One byte is taken per clock while in_stall is low; each packet passes through an
// input register, one pass of decode logic and a four-entry packet queue before it
// appears on the out_ channel. Most bytes yield zero or one packet, so the block
// sustains one byte per cycle while out_stall stays low; a status byte that both
// closes a system exclusive run that holds data and is a tune request yields two
// packets, and the single output port then drains them one at a time.
// in_stall rises only when the packet queue lacks room for two beats.
// out_last_of_run marks the final packet caused by a given input byte.
module midi_to_usb_midi_packetizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_midi_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_code_index,
  output logic [7:0] out_first_byte,
  output logic [7:0] out_second_byte,
  output logic [7:0] out_third_byte,
  output logic       out_last_of_run
);

  logic [7:0] byte_r;
  logic       vld_r, vld_nxt;
  logic       fire;
  logic       room;
  logic       pop;
  midi_pkt_pkg::dec_out_t dec;
  midi_pkt_pkg::packet_t  head;

  assign fire     = vld_r & room;
  assign in_stall = vld_r & ~room;
  assign pop      = out_valid & ~out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && !in_stall) begin
      vld_nxt = 1'b1;
    end else if (fire) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_midi_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  midi_pkt_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .midi_byte (byte_r),
    .dec       (dec)
  );

  midi_pkt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (dec),
    .pop       (pop),
    .head      (head),
    .not_empty (out_valid),
    .room      (room)
  );

  assign out_code_index  = head.cin;
  assign out_first_byte  = head.b0;
  assign out_second_byte = head.b1;
  assign out_third_byte  = head.b2;
  assign out_last_of_run = head.last;

endmodule

@@ bench/midi_to_usb_midi_packetizer_test.sv @@
`timescale 1ns / 1ps

module midi_to_usb_midi_packetizer_test;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int LONG_HOLD     = 300;
  localparam int BURST_BYTES   = 40;
  localparam int DIRECTED_ROWS = 27;

  typedef enum logic [1:0] {
    ROW_PREDICTED,
    ROW_LITERAL,
    ROW_SILENT
  } row_kind_t;

  typedef struct packed {
    logic [7:0]            midi;
    row_kind_t             kind;
    midi_pkt_pkg::packet_t lit;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_midi_byte;
  logic       out_valid;
  logic       out_stall;
  logic [3:0] out_code_index;
  logic [7:0] out_first_byte;
  logic [7:0] out_second_byte;
  logic [7:0] out_third_byte;
  logic       out_last_of_run;

  midi_to_usb_midi_packetizer DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_midi_byte    (in_midi_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_index  (out_code_index),
    .out_first_byte  (out_first_byte),
    .out_second_byte (out_second_byte),
    .out_third_byte  (out_third_byte),
    .out_last_of_run (out_last_of_run)
  );

  // Packet assembler state, mirrored from the block's behavior
  logic [7:0] run_status;
  logic [7:0] asm_bytes [0:2];
  logic [2:0] held;
  logic [1:0] need;
  logic       sysex_open;

  midi_pkt_pkg::packet_t fresh_pkts [0:1];
  int                    fresh_n;
  midi_pkt_pkg::packet_t pending_pkts [$];

  int send_idle;
  int recv_idle;
  bit hold_req;
  int items_sent;
  int pkts_checked;
  int mismatches;
  int cycles;

  stim_row_t steps [0:DIRECTED_ROWS-1] = '{
    '{8'hF8, ROW_LITERAL,   '{midi_pkt_pkg::CIN_SINGLE, 8'hF8, 8'h00, 8'h00, 1'b1}},
    '{8'h00, ROW_SILENT,    '0},
    '{8'h90, ROW_PREDICTED, '0},
    '{8'h7F, ROW_PREDICTED, '0},
    '{8'h00, ROW_PREDICTED, '0},
    '{8'h40, ROW_PREDICTED, '0},
    '{8'h41, ROW_PREDICTED, '0},
    '{8'hCF, ROW_PREDICTED, '0},
    '{8'h7F, ROW_PREDICTED, '0},
    '{8'hF2, ROW_PREDICTED, '0},
    '{8'h00, ROW_PREDICTED, '0},
    '{8'hFF, ROW_LITERAL,   '{midi_pkt_pkg::CIN_SINGLE, 8'hFF, 8'h00, 8'h00, 1'b1}},
    '{8'h7F, ROW_PREDICTED, '0},
    '{8'h33, ROW_SILENT,    '0},
    '{8'hF6, ROW_LITERAL,   '{midi_pkt_pkg::CIN_COMMON1, 8'hF6, 8'h00, 8'h00, 1'b1}},
    '{8'hF4, ROW_SILENT,    '0},
    '{8'hF0, ROW_PREDICTED, '0},
    '{8'h01, ROW_PREDICTED, '0},
    '{8'h02, ROW_PREDICTED, '0},
    '{8'hF7, ROW_LITERAL,   '{midi_pkt_pkg::CIN_COMMON1, 8'hF7, 8'h00, 8'h00, 1'b1}},
    '{8'hF0, ROW_PREDICTED, '0},
    '{8'h05, ROW_PREDICTED, '0},
    '{8'hF6, ROW_PREDICTED, '0},
    '{8'hFD, ROW_PREDICTED, '0},
    '{8'hF7, ROW_SILENT,    '0},
    '{8'hF1, ROW_PREDICTED, '0},
    '{8'h7F, ROW_PREDICTED, '0}
  };

  function automatic logic [1:0] frame_len(input logic [7:0] s);
    if (s[7] && s < midi_pkt_pkg::ST_SYSTEM_MIN) begin
      return (s[6:4] == midi_pkt_pkg::KIND_PROG_CHANGE ||
              s[6:4] == midi_pkt_pkg::KIND_CHAN_PRESS) ? 2'd2 : 2'd3;
    end
    case (s)
      midi_pkt_pkg::ST_MTC_QFRAME, midi_pkt_pkg::ST_SONG_SEL: return 2'd2;
      midi_pkt_pkg::ST_SONG_POS:                              return 2'd3;
      midi_pkt_pkg::ST_TUNE_REQ:                              return 2'd1;
      default:                                                return 2'd0;
    endcase
  endfunction

  function automatic logic [3:0] frame_cin(input logic [7:0] s);
    if (s[7] && s < midi_pkt_pkg::ST_SYSTEM_MIN) begin
      return s[7:4];
    end
    case (s)
      midi_pkt_pkg::ST_MTC_QFRAME, midi_pkt_pkg::ST_SONG_SEL: return midi_pkt_pkg::CIN_COMMON2;
      midi_pkt_pkg::ST_SONG_POS:  return midi_pkt_pkg::CIN_COMMON3;
      midi_pkt_pkg::ST_TUNE_REQ:  return midi_pkt_pkg::CIN_COMMON1;
      default:                    return midi_pkt_pkg::CIN_NONE;
    endcase
  endfunction

  function automatic logic [7:0] rand_data();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return 8'h00;
    end else if (pick == 1) begin
      return 8'h7F;
    end
    return 8'($urandom_range(0, 127));
  endfunction

  task automatic add_pkt(input logic [3:0] cin, input int len);
    fresh_pkts[fresh_n].cin  = cin;
    fresh_pkts[fresh_n].b0   = asm_bytes[0];
    fresh_pkts[fresh_n].b1   = (len > 1) ? asm_bytes[1] : 8'h00;
    fresh_pkts[fresh_n].b2   = (len > 2) ? asm_bytes[2] : 8'h00;
    fresh_pkts[fresh_n].last = 1'b0;
    fresh_n++;
  endtask

  task automatic start_status(input logic [7:0] b);
    asm_bytes = '{b, 8'h00, 8'h00};
    held = 3'd1;
    if (b == midi_pkt_pkg::ST_SYSEX_START) begin
      need       = midi_pkt_pkg::SYSEX_PKT_LEN;
      sysex_open = 1'b1;
      run_status = midi_pkt_pkg::NO_STATUS;
    end else begin
      run_status = (b < midi_pkt_pkg::ST_SYSTEM_MIN) ? b : midi_pkt_pkg::NO_STATUS;
      need       = frame_len(b);
      if (need == 2'd1) begin
        add_pkt(frame_cin(b), 1);
        held = 3'd0;
        need = 2'd0;
      end
    end
  endtask

  // Work out the packets that one accepted byte yields into fresh_pkts
  task automatic decode_midi(input logic [7:0] b);
    logic [2:0] cnt;
    fresh_n = 0;
    if (b >= midi_pkt_pkg::ST_REALTIME_MIN) begin
      fresh_pkts[0] = '{midi_pkt_pkg::CIN_SINGLE, b, 8'h00, 8'h00, 1'b0};
      fresh_n = 1;
    end else if (b[7]) begin
      if (sysex_open) begin
        cnt = (held > 3'd2) ? 3'd2 : held;
        sysex_open = 1'b0;
        if (b == midi_pkt_pkg::ST_SYSEX_END) begin
          if (cnt == 3'd0) begin
            asm_bytes = '{8'h00, 8'h00, 8'h00};
          end
          asm_bytes[cnt] = midi_pkt_pkg::ST_SYSEX_END;
          cnt++;
          add_pkt(4'(midi_pkt_pkg::CIN_SX_DATA + cnt), int'(cnt));
          held = 3'd0;
          need = 2'd0;
        end else begin
          // close the open run with what it holds, then take the new status
          if (cnt > 3'd0) begin
            add_pkt(4'(midi_pkt_pkg::CIN_SX_DATA + cnt), int'(cnt));
          end
          held = 3'd0;
          need = 2'd0;
          start_status(b);
        end
      end else begin
        start_status(b);
      end
    end else if (sysex_open) begin
      if (held == 3'd0) begin
        asm_bytes = '{b, 8'h00, 8'h00};
        held = 3'd1;
        need = midi_pkt_pkg::SYSEX_PKT_LEN;
      end else if (held < 3'd3) begin
        asm_bytes[held] = b;
        held++;
      end
      if (held >= 3'd3) begin
        add_pkt(midi_pkt_pkg::CIN_SX_DATA, 3);
        held = 3'd0;
        need = 2'd0;
      end
    end else begin
      if (held == 3'd0) begin
        if (run_status != midi_pkt_pkg::NO_STATUS) begin
          asm_bytes = '{run_status, b, 8'h00};
          held = 3'd2;
          need = frame_len(run_status);
        end
      end else if (need != 2'd0 && held < {1'b0, need} && held < 3'd3) begin
        asm_bytes[held] = b;
        held++;
      end
      if (need != 2'd0 && held == {1'b0, need}) begin
        add_pkt(frame_cin(asm_bytes[0]), int'(held));
        held = 3'd0;
        need = 2'd0;
      end
    end
    if (fresh_n > 0) begin
      fresh_pkts[fresh_n-1].last = 1'b1;
    end
  endtask

  // Present one byte, wait for the beat, then book its packets
  task automatic offer(input logic [7:0] b, input row_kind_t kind = ROW_PREDICTED,
                       input midi_pkt_pkg::packet_t lit = '0);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_midi_byte <= b;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    decode_midi(b);
    items_sent++;
    case (kind)
      ROW_PREDICTED: begin
        for (int i = 0; i < fresh_n; i++) begin
          pending_pkts.push_back(fresh_pkts[i]);
        end
      end
      ROW_LITERAL: pending_pkts.push_back(lit);
      default: ;
    endcase
  endtask

  // Occasionally slip a real-time byte in front of a data byte
  task automatic offer_data(input logic [7:0] b);
    if ($urandom_range(0, 99) < 5) begin
      offer(8'($urandom_range(midi_pkt_pkg::ST_REALTIME_MIN, 8'hFF)));
    end
    offer(b);
  endtask

  task automatic gen_message();
    int         pick;
    int         n;
    logic [7:0] st;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
      offer(st);
      n = int'(frame_len(st)) - 1;
      do begin
        for (int i = 0; i < n; i++) begin
          offer_data(rand_data());
        end
      end while ($urandom_range(0, 99) < 30);
    end else if (pick < 62) begin
      offer(midi_pkt_pkg::ST_SYSEX_START);
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        offer_data(rand_data());
      end
      if ($urandom_range(0, 99) < 80) begin
        offer(midi_pkt_pkg::ST_SYSEX_END);
      end else begin
        offer(8'($urandom_range(8'h80, midi_pkt_pkg::ST_TUNE_REQ)));
      end
    end else if (pick < 72) begin
      case ($urandom_range(0, 3))
        0:       st = midi_pkt_pkg::ST_MTC_QFRAME;
        1:       st = midi_pkt_pkg::ST_SONG_POS;
        2:       st = midi_pkt_pkg::ST_SONG_SEL;
        default: st = midi_pkt_pkg::ST_TUNE_REQ;
      endcase
      offer(st);
      n = int'(frame_len(st)) - 1;
      for (int i = 0; i < n; i++) begin
        offer_data(rand_data());
      end
    end else if (pick < 80) begin
      offer(8'($urandom_range(midi_pkt_pkg::ST_REALTIME_MIN, 8'hFF)));
    end else begin
      offer(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic drain_packets();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pkts.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Receiver: random stall, or a long hold when asked
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        for (int i = 0; i < LONG_HOLD; i++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    midi_pkt_pkg::packet_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pkts.size() == 0) begin
        $error("packet with none pending: cin %h bytes %h %h %h last %b", out_code_index,
               out_first_byte, out_second_byte, out_third_byte, out_last_of_run);
        mismatches++;
      end else begin
        want = pending_pkts.pop_front();
        pkts_checked++;
        if (out_code_index !== want.cin) begin
          $error("code_index: expected %h, actual %h", want.cin, out_code_index);
          mismatches++;
        end
        if (out_first_byte !== want.b0) begin
          $error("first_byte: expected %h, actual %h", want.b0, out_first_byte);
          mismatches++;
        end
        if (out_second_byte !== want.b1) begin
          $error("second_byte: expected %h, actual %h", want.b1, out_second_byte);
          mismatches++;
        end
        if (out_third_byte !== want.b2) begin
          $error("third_byte: expected %h, actual %h", want.b2, out_third_byte);
          mismatches++;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run: expected %b, actual %b", want.last, out_last_of_run);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d packets still pending", cycles,
               pending_pkts.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_midi_byte <= 8'h00;
    hold_req     = 1'b0;
    items_sent   = 0;
    pkts_checked = 0;
    mismatches   = 0;
    cycles       = 0;
    run_status   = midi_pkt_pkg::NO_STATUS;
    asm_bytes    = '{8'h00, 8'h00, 8'h00};
    held         = 3'd0;
    need         = 2'd0;
    sysex_open   = 1'b0;
    send_idle    = 9;
    recv_idle    = 86;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[k]) begin
      offer(steps[k].midi, steps[k].kind, steps[k].lit);
    end
    while (items_sent < 300) begin
      gen_message();
    end
    drain_packets();

    send_idle = 86;
    recv_idle = 9;
    while (items_sent < 560) begin
      gen_message();
    end
    drain_packets();

    // hold the output off and keep feeding a burst of real-time bytes so the input stalls
    send_idle = 0;
    recv_idle = 0;
    hold_req  = 1'b1;
    for (int i = 0; i < BURST_BYTES; i++) begin
      offer(8'($urandom_range(midi_pkt_pkg::ST_REALTIME_MIN, 8'hFF)));
    end
    drain_packets();

    while (items_sent < 850) begin
      gen_message();
    end
    drain_packets();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d MIDI bytes and checked %0d USB-MIDI packets", items_sent, pkts_checked);
    $display("Covered channel, common, sysex and real-time traffic under three stall mixes");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
